// ===== sv/poc_pkg.sv =====
`timescale 1ns / 1ps

package poc_pkg;

  // Defaults of the top-level parameters.
  localparam int PATTERN_MAX_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  // Pattern register: eight bytes, first pattern byte in the low byte.
  localparam int PAT_BYTES  = 8;
  localparam int PAT_W      = 8 * PAT_BYTES;
  localparam int PLEN_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PAT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_OVERLAP_MODE   = 2'd2
  } poc_reg_e;

  // Per-byte status, built from the cell row and the input, handed to the tally stage.
  typedef struct packed {
    logic fire;
    logic window_hit;
    logic last;
  } poc_step_t;

endpackage

// ===== sv/poc_if.sv =====
`timescale 1ns / 1ps

interface poc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface poc_out_if #(
  parameter int COUNT_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic                   match_counted;
  logic [COUNT_WIDTH-1:0] match_total;
  logic                   text_done;

  modport source (output valid, output match_counted, output match_total,
                  output text_done, input ready);
  modport sink (input valid, input match_counted, input match_total,
                input text_done, output ready);
endinterface

// ===== sv/pattern_occurrence_counter_top.sv =====
`timescale 1ns / 1ps

// Counts occurrences of a configured byte pattern (1 to PATTERN_MAX bytes)
// in a stream of text bytes.
// Input channel in_ch carries one text byte per transfer plus end_of_text,
// which marks the last byte of a text. Output channel out_ch returns exactly
// one result per input byte: whether a counted match ends there, the running
// saturating count for the current text, and a copy of end_of_text.
// The configuration port writes pattern_bytes (index 0), pattern_length
// (index 1) and overlap_mode (index 2); write only while the block is idle.
// A byte's result is registered and is on out_ch in the cycle after its
// transfer. Throughput is one byte per cycle while the receiver takes
// results, set by the window cells that compare in parallel and shift on
// each transfer. When the receiver stalls, the result register holds its
// value and in_ch stays ready only if that result is taken in the same cycle.
// Reset clears the window, the counters and the result valid, and loads
// pattern 0, length 1 and overlapping mode. No clearing pass is needed.
// After the last byte of a text the window and counters return to zero.
module pattern_occurrence_counter_top #(
  parameter int PATTERN_MAX = poc_pkg::PATTERN_MAX_DEF,
  parameter int COUNT_WIDTH = poc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [poc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [poc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  poc_in_if.sink                         in_ch,
  poc_out_if.source                      out_ch
);
  import poc_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [PAT_W-1:0]  pattern_q;
  logic [PLEN_W-1:0] plen_q;
  logic              overlap_q;
  logic [LEN_W-1:0]  len_eff;
  logic              fire;
  logic              ready;
  logic [7:0]        chain [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] cell_eq;
  poc_step_t         step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= PLEN_W'(1);
      overlap_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (poc_reg_e'(cfg_index_i))
        REG_PATTERN_BYTES:  pattern_q <= cfg_data_i[PAT_W-1:0];
        REG_PATTERN_LENGTH: plen_q    <= cfg_data_i[PLEN_W-1:0];
        REG_OVERLAP_MODE:   overlap_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A length above the window acts as the full window.
  always_comb begin
    if (int'(plen_q) > PATTERN_MAX) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = LEN_W'(plen_q);
    end
  end

  assign fire        = in_ch.valid && ready;
  assign in_ch.ready = ready;
  assign chain[0]    = in_ch.text_byte;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    poc_cell #(
      .PATTERN_MAX(PATTERN_MAX),
      .CELL_IDX   (i),
      .LEN_W      (LEN_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (fire),
      .clear_i  (in_ch.end_of_text),
      .byte_i   (chain[i]),
      .pattern_i(pattern_q),
      .len_i    (len_eff),
      .byte_o   (chain[i+1]),
      .eq_o     (cell_eq[i])
    );
  end

  assign step.fire       = fire;
  assign step.window_hit = &cell_eq;
  assign step.last       = in_ch.end_of_text;

  poc_tally #(
    .PATTERN_MAX(PATTERN_MAX),
    .COUNT_WIDTH(COUNT_WIDTH),
    .LEN_W      (LEN_W)
  ) u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .len_i    (len_eff),
    .overlap_i(overlap_q),
    .ready_o  (ready),
    .out      (out_ch)
  );

  // Every transfer in produces a result, and the end marker follows it.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=>
      (out_ch.valid && (out_ch.text_done == $past(in_ch.end_of_text))))
    else $error("missing or wrong result after an input transfer");

  // A counted match always leaves a nonzero running count.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.match_counted) |-> (out_ch.match_total != '0))
    else $error("counted match with zero total");

  // With the result register empty the input side must be open.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== sv/poc_cell.sv =====
`timescale 1ns / 1ps

module poc_cell #(
  parameter int PATTERN_MAX = poc_pkg::PATTERN_MAX_DEF,
  parameter int CELL_IDX    = 0,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    shift_i,
  input  logic                    clear_i,
  input  logic [7:0]              byte_i,
  input  logic [poc_pkg::PAT_W-1:0] pattern_i,
  input  logic [LEN_W-1:0]        len_i,
  output logic [7:0]              byte_o,
  output logic                    eq_o
);
  import poc_pkg::*;

  logic [7:0] byte_q, byte_d;
  logic [7:0] pat_byte;
  logic       in_use;

  // Cell i sees the byte i places back, so it is compared with pattern
  // byte len-1-i. Cells beyond the pattern length always agree.
  always_comb begin
    pat_byte = 8'd0;
    for (int k = 0; k < PAT_BYTES; k++) begin
      if (int'(len_i) - 1 - CELL_IDX == k) begin
        pat_byte = pattern_i[8*k +: 8];
      end
    end
  end

  assign in_use = int'(len_i) > CELL_IDX;
  assign eq_o   = !in_use || (byte_i == pat_byte);
  assign byte_d = clear_i ? 8'd0 : byte_i;
  assign byte_o = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else if (shift_i) begin
      byte_q <= byte_d;
    end
  end

endmodule

// ===== sv/poc_tally.sv =====
`timescale 1ns / 1ps

module poc_tally #(
  parameter int PATTERN_MAX = poc_pkg::PATTERN_MAX_DEF,
  parameter int COUNT_WIDTH = poc_pkg::COUNT_WIDTH_DEF,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  poc_pkg::poc_step_t step_i,
  input  logic [LEN_W-1:0]   len_i,
  input  logic               overlap_i,
  output logic               ready_o,
  poc_out_if.source          out
);
  import poc_pkg::*;

  localparam int HOLD_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [LEN_W-1:0]       seen_q, seen_d, seen_new;
  logic [HOLD_W-1:0]      hold_q, hold_d, hold_new;
  logic [COUNT_WIDTH-1:0] count_q, count_d, count_new;
  logic                   hit;
  logic                   valid_q, valid_d;
  logic                   counted_q;
  logic [COUNT_WIDTH-1:0] total_q;
  logic                   done_q;

  always_comb begin
    seen_new = (int'(seen_q) < PATTERN_MAX) ? seen_q + LEN_W'(1) : seen_q;
    hit      = step_i.window_hit && (len_i != '0) && (seen_new >= len_i);
    hold_new = hold_q;
    if (hold_q != '0) begin
      if (!overlap_i) begin
        hit = 1'b0;
      end
      hold_new = hold_q - HOLD_W'(1);
    end
    count_new = count_q;
    if (hit) begin
      if (count_q != COUNT_MAX) begin
        count_new = count_q + COUNT_WIDTH'(1);
      end
      // In non-overlapping mode, matches that end inside a counted one are skipped.
      if (!overlap_i) begin
        hold_new = HOLD_W'(len_i - LEN_W'(1));
      end
    end
  end

  // The last byte of a text clears the per-text state once its result is formed.
  always_comb begin
    seen_d  = seen_q;
    hold_d  = hold_q;
    count_d = count_q;
    if (step_i.fire) begin
      seen_d  = step_i.last ? '0 : seen_new;
      hold_d  = step_i.last ? '0 : hold_new;
      count_d = step_i.last ? '0 : count_new;
    end
  end

  // The result register frees up in the same cycle its transfer completes.
  assign ready_o = !valid_q || out.ready;
  assign valid_d = step_i.fire || (valid_q && !out.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      hold_q  <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      hold_q  <= hold_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.fire) begin
      counted_q <= hit;
      total_q   <= count_new;
      done_q    <= step_i.last;
    end
  end

  assign out.valid         = valid_q;
  assign out.match_counted = counted_q;
  assign out.match_total   = total_q;
  assign out.text_done     = done_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int WIN_DEPTH = poc_pkg::PATTERN_MAX_DEF;
  localparam int COUNT_W   = poc_pkg::COUNT_WIDTH_DEF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic               match_counted;
    logic [COUNT_W-1:0] match_total;
    logic               text_done;
  } occurrence_result_t;

  // Tracks the window, holdoff and running count of the block and keeps the
  // results it should return, oldest first.
  class pattern_tally;
    logic [poc_pkg::PAT_W-1:0]  pattern = '0;
    logic [poc_pkg::PLEN_W-1:0] pattern_len = 4'd1;
    logic                       overlap = 1'b1;
    logic [7:0]                 window [WIN_DEPTH];
    int                         seen;
    logic [2:0]                 holdoff;
    logic [COUNT_W-1:0]         tally;
    occurrence_result_t         pending_results [$];
    int                         errors;

    function new();
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = '0;
      seen    = 0;
      holdoff = '0;
      tally   = '0;
    endfunction

    function void set_register(poc_pkg::poc_reg_e idx, logic [poc_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        poc_pkg::REG_PATTERN_BYTES:  pattern = d;
        poc_pkg::REG_PATTERN_LENGTH: pattern_len = d[poc_pkg::PLEN_W-1:0];
        poc_pkg::REG_OVERLAP_MODE:   overlap = d[0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic eot);
      int                 len;
      int                 i;
      logic               hit;
      occurrence_result_t r;
      len = (pattern_len > WIN_DEPTH) ? WIN_DEPTH : int'(pattern_len);
      for (i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (seen < WIN_DEPTH) seen++;
      hit = 1'b0;
      // The oldest byte of the window slice lines up with the first pattern byte.
      if (len != 0 && seen >= len) begin
        hit = 1'b1;
        for (i = 0; i < len; i++) begin
          if (window[len-1-i] !== pattern[8*i +: 8]) hit = 1'b0;
        end
      end
      // The holdoff always counts down, but only blocks in non-overlapping mode.
      if (holdoff != 0) begin
        if (!overlap) hit = 1'b0;
        holdoff--;
      end
      if (hit) begin
        if (tally != COUNT_MAX) tally++;
        if (!overlap) holdoff = 3'(len - 1);
      end
      r.match_counted = hit;
      r.match_total   = tally;
      r.text_done     = eot;
      pending_results.push_back(r);
      if (eot) clear_text();
    endfunction

    function void check_result(logic mc, logic [COUNT_W-1:0] total, logic done);
      occurrence_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with none expected: match_counted %0b match_total %0d text_done %0b",
               mc, total, done);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (mc !== e.match_counted) begin
        $error("match_counted: expected %0b, actual %0b", e.match_counted, mc);
        errors++;
      end
      if (total !== e.match_total) begin
        $error("match_total: expected %0d, actual %0d", e.match_total, total);
        errors++;
      end
      if (done !== e.text_done) begin
        $error("text_done: expected %0b, actual %0b", e.text_done, done);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [poc_pkg::CFG_IDX_W-1:0]     cfg_index = poc_pkg::REG_PATTERN_BYTES;
  logic [poc_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
  bit                                idle_on = 1'b1;
  logic [poc_pkg::PAT_W-1:0]         cur_pattern = '0;
  int                                cur_len = 1;
  pattern_tally                      tally = new();

  poc_in_if                          in_ch ();
  poc_out_if #(.COUNT_WIDTH(COUNT_W)) out_ch ();

  pattern_occurrence_counter_top #(
    .PATTERN_MAX(WIN_DEPTH),
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) tally.take_byte(in_ch.text_byte, in_ch.end_of_text);
      if (out_ch.valid && out_ch.ready) begin
        tally.check_result(out_ch.match_counted, out_ch.match_total, out_ch.text_done);
      end
    end
  end

  // Result receiver with random stalls.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk_i);
    end
  end

  initial begin
    #8_000_000;
    $display("pattern_occurrence_counter_top verification failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer,
  // with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk_i);
  endtask

  // Sends the n low bytes of a word, lowest first.
  task automatic send_word(input logic [63:0] w, input int n, input logic ends_text);
    int i;
    for (i = 0; i < n; i++) send_byte(w[8*i +: 8], ends_text && i == n - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (tally.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input poc_pkg::poc_reg_e idx,
                           input logic [poc_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    tally.set_register(idx, d);
    @(negedge clk_i);
  endtask

  task automatic configure_phase(input int phase);
    logic [63:0] pat;
    logic [63:0] junk;
    logic [7:0]  a0;
    logic [7:0]  a1;
    int          mode;
    int          r;
    int          len;
    logic        ovl;
    int          i;
    mode = $urandom_range(0, 5);
    a0   = 8'($urandom);
    a1   = 8'($urandom);
    pat  = {$urandom, $urandom};
    if (mode == 0) pat = '0;
    else if (mode == 1) pat = '1;
    else if (mode > 2) begin
      // A two-letter alphabet makes overlapping and near-miss matches common.
      for (i = 0; i < 8; i++) pat[8*i +: 8] = $urandom_range(0, 1) ? a0 : a1;
    end
    r = $urandom_range(0, 19);
    if (r == 0) len = 0;
    else if (r == 1) len = $urandom_range(9, 15);
    else if (r < 5) len = 8;
    else if (r < 7) len = 1;
    else len = $urandom_range(1, 8);
    ovl = 1'($urandom_range(0, 1));
    if (phase == 0) begin
      pat = '1;
      len = 8;
      ovl = 1'b0;
    end else if (phase == 1) begin
      pat = '0;
      len = 1;
      ovl = 1'b1;
    end
    junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    wait_drained();
    write_reg(poc_pkg::REG_PATTERN_BYTES, pat);
    write_reg(poc_pkg::REG_PATTERN_LENGTH, {junk[63:4], 4'(len)});
    write_reg(poc_pkg::REG_OVERLAP_MODE, {junk[63:1], ovl});
    cur_pattern = pat;
    cur_len     = len;
  endtask

  // Texts built mostly from whole patterns and pattern bytes. A phase may end
  // in the middle of a text, so the next settings apply to its remainder.
  task automatic send_random_bytes(input int n_items);
    int         sent;
    int         tlen;
    int         k;
    int         j;
    int         pick;
    int         plen;
    logic [7:0] b;
    sent = 0;
    plen = (cur_len == 0) ? 1 : ((cur_len > WIN_DEPTH) ? WIN_DEPTH : cur_len);
    while (sent < n_items) begin
      tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      k = 0;
      while (k < tlen && sent < n_items) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          for (j = 0; j < plen && k < tlen && sent < n_items; j++) begin
            send_byte(cur_pattern[8*j +: 8], k == tlen - 1);
            k++;
            sent++;
          end
        end else begin
          j = $urandom_range(0, plen - 1);
          b = (pick < 8) ? cur_pattern[8*j +: 8] : 8'($urandom);
          send_byte(b, k == tlen - 1);
          k++;
          sent++;
        end
      end
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
  endtask

  initial begin
    int phase;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: pattern zero, length one, overlapping.
    send_word(64'h00_5A_00, 3, 1'b1);

    wait_drained();
    write_reg(poc_pkg::REG_PATTERN_BYTES, 64'h61_62_61);
    write_reg(poc_pkg::REG_PATTERN_LENGTH, 64'd3);
    write_reg(poc_pkg::REG_OVERLAP_MODE, 64'd0);
    send_word(64'h61_62_61_62_61, 5, 1'b1);
    wait_drained();
    write_reg(poc_pkg::REG_OVERLAP_MODE, 64'd1);
    send_word(64'h61_62_61_62_61, 5, 1'b1);
    // A text shorter than the pattern.
    send_word(64'h62_61, 2, 1'b1);

    wait_drained();
    write_reg(poc_pkg::REG_PATTERN_LENGTH, 64'd0);
    send_word(64'h61_61, 2, 1'b1);

    // A length above the window acts as the full window.
    wait_drained();
    write_reg(poc_pkg::REG_PATTERN_BYTES, '1);
    write_reg(poc_pkg::REG_PATTERN_LENGTH, 64'd13);
    write_reg(poc_pkg::REG_OVERLAP_MODE, 64'd0);
    send_word('1, 8, 1'b1);

    for (phase = 0; phase < 20; phase++) begin
      configure_phase(phase);
      idle_on = ($urandom_range(0, 3) != 0);
      send_random_bytes(100);
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (5) @(negedge clk_i);
    if (tally.pending() != 0) begin
      $error("%0d results never arrived", tally.pending());
      tally.errors++;
    end
    if (tally.errors == 0) begin
      $display("pattern_occurrence_counter_top verification clean");
    end else begin
      $display("pattern_occurrence_counter_top verification failed");
    end
    $finish;
  end

endmodule
